@@ rtl/lksb_pkg.sv @@
// Shared constants for the keyed sample buffer: field widths, defaults and operation codes.
package lksb_pkg;

  localparam int OPCODE_W          = 2;
  localparam int KEY_W             = 16;
  localparam int PAYLOAD_IN_W      = 64;
  localparam int KEEP_W            = 5;
  localparam int COUNT_OUT_W       = 5;
  localparam int SLOT_OUT_W        = 4;

  localparam int ENTRIES_DEF       = 16;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PRUNE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

endpackage

@@ rtl/lksb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module lksb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lru_keyed_sample_buffer_top.sv @@
// Keyed sample buffer with least-recently-used ages: top level and sequencer.
//
// A command word is taken when start is high and busy is low. Each command
// produces exactly one result word, shown for a single cycle with done high;
// the receiver cannot stall, so it must capture the word in that cycle. An
// insert walks the table twice, reading the key and age memories at one
// shared address: a lookup pass (ST_SCAN), a decision state (ST_DECIDE), an
// age update pass (ST_AGE) and a posting state (ST_DONE), with busy high
// throughout. An insert that repeats the previous key skips the age pass.
// A prune takes only the age pass. A clear or an undefined opcode goes
// straight to the posting state. In every case done is high in the first
// cycle in which busy is low again, and a new command may be presented in
// that very cycle. The pass length is set by the single read port of the
// age memory, which is read and written back one slot per cycle. No
// clearing pass is needed after reset: valid bits live in flip-flops and a
// slot that is not valid reads as age zero.
module lru_keyed_sample_buffer_top import lksb_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPCODE_W-1:0]     opcode,
  input  logic [KEY_W-1:0]        sample_key,
  input  logic [PAYLOAD_IN_W-1:0] sample_payload,
  input  logic [KEEP_W-1:0]       keep_count,
  output logic                    done,
  output logic                    table_full,
  output logic [COUNT_OUT_W-1:0]  entry_count,
  output logic                    key_hit,
  output logic [SLOT_OUT_W-1:0]   slot_written,
  output logic                    payload_stored,
  output logic                    evicted_oldest
);

  // Slot index and count/age widths follow from the depth; the comparison width also covers KEEP_W.
  localparam int IW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int CMPW    = (CW > KEEP_W) ? CW : KEEP_W;
  localparam int STORE_W = KEY_W + PAYLOAD_WIDTH;
  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_AGE    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]               state;

  // Latched command word.
  logic [OPCODE_W-1:0]      op;
  logic [KEY_W-1:0]         key;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic [KEEP_W-1:0]        keep;

  // Table state held in flip-flops.
  logic [ENTRIES-1:0]       valid;
  logic [CW-1:0]            count;
  logic [KEY_W-1:0]         prev_key;
  logic                     prev_valid;

  // Walk pipeline: idx is the address being issued, pend_idx the slot whose
  // read data is arriving in this cycle.
  logic [IW-1:0]            idx;
  logic                     issuing;
  logic                     pend;
  logic [IW-1:0]            pend_idx;

  // Lookup pass results.
  logic                     hit_found;
  logic [IW-1:0]            hit_idx;
  logic [CW-1:0]            hit_age;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic [CW-1:0]            best_age;
  logic [IW-1:0]            best_idx;

  // Age pass controls.
  logic [IW-1:0]            target;
  logic                     promote;
  logic [CW-1:0]            kept;

  // Result fields gathered along the way, posted in ST_DONE.
  logic                     res_hit;
  logic [IW-1:0]            res_slot;
  logic                     res_stored;
  logic                     res_evicted;

  // Memory ports.
  logic                     store_we;
  logic [STORE_W-1:0]       store_rdata;
  logic                     age_we;
  logic [CW-1:0]            age_wdata;
  logic [CW-1:0]            age_rdata;

  // Decoded view of the slot in flight and of the decision.
  logic [KEY_W-1:0]         cur_key;
  logic                     cur_valid;
  logic [CW-1:0]            cur_age;
  logic                     cur_pruned;
  logic                     pass_end;
  logic                     dec_repeat;
  logic                     dec_evict;
  logic [IW-1:0]            dec_slot;

  assign busy = (state != ST_IDLE);

  assign cur_key    = store_rdata[KEY_W-1:0];
  assign cur_valid  = valid[pend_idx];
  assign cur_age    = cur_valid ? age_rdata : '0;
  assign cur_pruned = (CMPW'(cur_age) > CMPW'(keep));
  assign pass_end   = pend && (pend_idx == LAST_SLOT);

  // A hit on the key of the previous insert leaves the table untouched.
  // On a miss the lowest free slot wins; with none left the oldest goes.
  assign dec_repeat = hit_found && prev_valid && (prev_key == key);
  assign dec_evict  = !hit_found && !free_found;
  assign dec_slot   = hit_found ? hit_idx : (free_found ? free_idx : best_idx);
  assign store_we   = (state == ST_DECIDE) && !dec_repeat;

  // Age write-back. A prune only drops valid bits, so it writes nothing.
  always_comb begin
    age_we    = 1'b0;
    age_wdata = cur_age;
    if (state == ST_AGE && pend && cur_valid && op == OP_INSERT) begin
      age_we = 1'b1;
      if (pend_idx == target) begin
        age_wdata = CW'(1);
      end else if (!promote || cur_age < hit_age) begin
        age_wdata = cur_age + CW'(1);
      end
    end
  end

  lksb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (dec_slot),
    .wdata ({payload, key}),
    .raddr (idx),
    .rdata (store_rdata)
  );

  lksb_ram #(
    .WIDTH (CW),
    .DEPTH (ENTRIES)
  ) u_age (
    .clk   (clk),
    .we    (age_we),
    .waddr (pend_idx),
    .wdata (age_wdata),
    .raddr (idx),
    .rdata (age_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      valid          <= '0;
      count          <= '0;
      prev_key       <= '0;
      prev_valid     <= 1'b0;
      issuing        <= 1'b0;
      pend           <= 1'b0;
      done           <= 1'b0;
      table_full     <= 1'b0;
      entry_count    <= '0;
      key_hit        <= 1'b0;
      slot_written   <= '0;
      payload_stored <= 1'b0;
      evicted_oldest <= 1'b0;
    end else begin
      done     <= 1'b0;
      pend     <= issuing;
      pend_idx <= idx;
      if (issuing) begin
        if (idx == LAST_SLOT) begin
          issuing <= 1'b0;
        end else begin
          idx <= idx + IW'(1);
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            op          <= opcode;
            key         <= sample_key;
            payload     <= sample_payload[PAYLOAD_WIDTH-1:0];
            keep        <= keep_count;
            res_hit     <= 1'b0;
            res_slot    <= '0;
            res_stored  <= 1'b0;
            res_evicted <= 1'b0;
            hit_found   <= 1'b0;
            free_found  <= 1'b0;
            best_age    <= '0;
            best_idx    <= '0;
            kept        <= '0;
            idx         <= '0;
            case (opcode)
              OP_INSERT: begin
                issuing <= 1'b1;
                state   <= ST_SCAN;
              end
              OP_PRUNE: begin
                issuing <= 1'b1;
                state   <= ST_AGE;
              end
              OP_CLEAR: begin
                valid <= '0;
                count <= '0;
                state <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (pend) begin
            if (cur_valid && cur_key == key && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= pend_idx;
              hit_age   <= cur_age;
            end
            if (!cur_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
            end
            if (cur_valid && cur_age > best_age) begin
              best_age <= cur_age;
              best_idx <= pend_idx;
            end
          end
          if (pass_end) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          res_hit     <= hit_found;
          res_slot    <= dec_slot;
          res_stored  <= !dec_repeat;
          res_evicted <= dec_evict;
          target      <= dec_slot;
          promote     <= hit_found;
          prev_key    <= key;
          prev_valid  <= 1'b1;
          if (!hit_found) begin
            valid[dec_slot] <= 1'b1;
            if (!dec_evict) begin
              count <= count + CW'(1);
            end
          end
          if (dec_repeat) begin
            state <= ST_DONE;
          end else begin
            idx     <= '0;
            issuing <= 1'b1;
            state   <= ST_AGE;
          end
        end

        ST_AGE: begin
          if (pend && op == OP_PRUNE && cur_valid) begin
            if (cur_pruned) begin
              valid[pend_idx] <= 1'b0;
            end else begin
              kept <= kept + CW'(1);
            end
          end
          if (pass_end) begin
            if (op == OP_PRUNE) begin
              count <= kept + CW'(cur_valid && !cur_pruned);
            end
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          done           <= 1'b1;
          table_full     <= (count == CW'(ENTRIES));
          entry_count    <= COUNT_OUT_W'(count);
          key_hit        <= res_hit;
          slot_written   <= SLOT_OUT_W'(res_slot);
          payload_stored <= res_stored;
          evicted_oldest <= res_evicted;
          state          <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count must always agree with the valid bits once a command is over.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == int'(count)))
    else $error("entry count disagrees with valid bits");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(count) <= ENTRIES))
    else $error("entry count above table depth");

  // An eviction only happens on a miss into a full table.
  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_oldest) |-> (table_full && payload_stored && !key_hit))
    else $error("eviction reported without a full table miss");

  a_done_after_post: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DONE))
    else $error("result word posted outside the posting state");

endmodule
